// ===== rtl/shortest_path_dijkstra_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SHORTEST_PATH_DIJKSTRA_DEFINES_SVH
`define SHORTEST_PATH_DIJKSTRA_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SPD_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Condition that must never be seen outside reset.
`define SPD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

// ===== rtl/spd_pkg.sv =====
// Types, constants and codes of the shortest-path engine.
package spd_pkg;
	localparam int NUM_V = 64;
	localparam int VID_W = 6;
	localparam int DIST_W = 27;
	localparam logic [DIST_W-1:0] UNREACHED = 27'd99999999;
	localparam int MAX_EDGES_DEF = 256;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_SRC = 3'd1;
	localparam logic [2:0] ST_BAD_DST = 3'd2;
	localparam logic [2:0] ST_UNREACH = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic [1:0]       kind;
		logic [VID_W-1:0] edge_from;
		logic [VID_W-1:0] edge_to;
		logic [15:0]      edge_weight;
		logic [7:0]       edge_label;
		logic [VID_W-1:0] source_vertex;
		logic [VID_W-1:0] target_vertex;
	} in_t;

	typedef struct packed {
		logic [VID_W-1:0]  vertex_id;
		logic [7:0]        via_label;
		logic              has_predecessor;
		logic [DIST_W-1:0] path_distance;
		logic              last_of_path;
		logic [2:0]        status;
	} out_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [VID_W-1:0] efrom;
		logic [VID_W-1:0] eto;
		logic [15:0]      weight;
		logic [7:0]       label;
		logic [VID_W-1:0] src;
		logic [VID_W-1:0] dst;
	} cmd_t;

	typedef struct packed {
		logic [VID_W-1:0] efrom;
		logic [VID_W-1:0] eto;
		logic [15:0]      weight;
		logic [7:0]       label;
	} edge_t;

	typedef struct packed {
		logic              hp;
		logic [VID_W-1:0]  predv;
		logic [7:0]        label;
		logic [DIST_W-1:0] dval;
	} dent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

// ===== rtl/spd_front.sv =====
// Front end: takes commands, drops unused kinds and masks the weight.
module spd_front #(
	parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
	input  logic             start,
	output logic             busy,
	input  spd_pkg::in_t     item,
	input  spd_pkg::q_stat_t qstat,
	output logic             push,
	output spd_pkg::cmd_t    cmd
);
	localparam logic [15:0] WMASK = (WEIGHT_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << WEIGHT_BITS) - 32'd1);

	logic keep;

	always_comb begin
		unique case (item.kind)
			spd_pkg::KIND_LOAD, spd_pkg::KIND_QUERY, spd_pkg::KIND_CLEAR: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign busy = qstat.full;
	assign push = start && !qstat.full && keep;
	assign cmd.op = item.kind;
	assign cmd.efrom = item.edge_from;
	assign cmd.eto = item.edge_to;
	assign cmd.weight = item.edge_weight & WMASK;
	assign cmd.label = item.edge_label;
	assign cmd.src = item.source_vertex;
	assign cmd.dst = item.target_vertex;
endmodule

// ===== rtl/spd_queue.sv =====
// Short command queue between front and back end.
module spd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  spd_pkg::cmd_t    wdata,
	input  logic             pop,
	output spd_pkg::cmd_t    rdata,
	output spd_pkg::q_stat_t qstat
);
	localparam int D = spd_pkg::QUEUE_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	spd_pkg::cmd_t  slot_q [D];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_pop;

	assign do_pop = pop && (cnt_q != '0);
	assign rdata = slot_q[rp_q];
	assign qstat.full = (cnt_q == CW'(D));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + 1'b1;
			if (do_pop) rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== rtl/spd_back.sv =====
// Back end: edge store, Dijkstra sequencer and path output.
module spd_back #(
	parameter int MAX_EDGES = spd_pkg::MAX_EDGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  spd_pkg::q_stat_t qstat,
	input  spd_pkg::cmd_t    cmd,
	output logic             pop,
	output logic             strobe,
	output spd_pkg::out_t    result
);
	localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC_W = $clog2(MAX_EDGES + 1);
	localparam int V = spd_pkg::NUM_V;
	localparam int VW = spd_pkg::VID_W;
	localparam int DW = spd_pkg::DIST_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_SCAN = 4'd2;
	localparam logic [3:0] S_EA   = 4'd3;
	localparam logic [3:0] S_EB   = 4'd4;
	localparam logic [3:0] S_EC   = 4'd5;
	localparam logic [3:0] S_RES  = 4'd6;
	localparam logic [3:0] S_WA   = 4'd7;
	localparam logic [3:0] S_WB   = 4'd8;
	localparam logic [3:0] S_OA   = 4'd9;
	localparam logic [3:0] S_OB   = 4'd10;
	localparam logic [3:0] S_OC   = 4'd11;

	spd_pkg::edge_t emem [MAX_EDGES];
	spd_pkg::dent_t dmem [V];
	logic [VW-1:0]  cmem [V];

	spd_pkg::edge_t e_rd_q, ed_q;
	spd_pkg::dent_t dm_rd_q, dm_wd;
	logic [VW-1:0]  c_rd_q, dm_ra, dm_wa;
	logic           dm_we;

	logic [3:0]     state_q;
	logic [EC_W-1:0] ecnt_q, eidx_q;
	logic [V-1:0]   present_q, done_q, reach_q;
	logic [VW-1:0]  src_q, dst_q, cur_q, v_q, i_s1, ov_q;
	logic [DW-1:0]  curd_q, bestd_q;
	logic           found_q, v_s1;
	logic [VW:0]    idx_q, n_q, j_q;

	logic [DW:0]    sum;
	logic [DW-1:0]  sum_sat, old_d;
	logic           better;
	logic           emit;

	assign sum = {1'b0, curd_q} + (DW + 1)'(ed_q.weight);
	assign sum_sat = (sum > {1'b0, spd_pkg::UNREACHED}) ? spd_pkg::UNREACHED : sum[DW-1:0];
	assign old_d = reach_q[ed_q.eto] ? dm_rd_q.dval : spd_pkg::UNREACHED;
	assign better = sum_sat < old_d;
	assign pop = (state_q == S_IDLE) && !qstat.empty;

	// status results from the head command, the unreachable case, and each path step
	assign emit = ((state_q == S_IDLE) && !qstat.empty &&
		(((cmd.op == spd_pkg::KIND_LOAD) && (ecnt_q == EC_W'(MAX_EDGES))) ||
		((cmd.op != spd_pkg::KIND_LOAD) && (cmd.op != spd_pkg::KIND_CLEAR) &&
		(!present_q[cmd.src] || !present_q[cmd.dst])))) ||
		((state_q == S_RES) && !reach_q[dst_q]) || (state_q == S_OC);

	always_comb begin
		dm_ra = '0;
		dm_we = 1'b0;
		dm_wa = src_q;
		dm_wd = '0;
		unique case (state_q)
			S_INIT: dm_we = 1'b1;
			S_SCAN: dm_ra = idx_q[VW-1:0];
			S_EB:   dm_ra = e_rd_q.eto;
			S_EC: begin
				dm_we = better;
				dm_wa = ed_q.eto;
				dm_wd = '{hp: 1'b1, predv: cur_q, label: ed_q.label, dval: sum_sat};
			end
			S_WA:   dm_ra = v_q;
			S_OB:   dm_ra = c_rd_q;
			default: dm_ra = '0;
		endcase
	end

	// store reads are registered
	always_ff @(posedge clk) begin
		if (dm_we) dmem[dm_wa] <= dm_wd;
		dm_rd_q <= dmem[dm_ra];
		if (pop && cmd.op == spd_pkg::KIND_LOAD && ecnt_q != EC_W'(MAX_EDGES))
			emem[ecnt_q[EA_W-1:0]] <= '{efrom: cmd.efrom, eto: cmd.eto,
				weight: cmd.weight, label: cmd.label};
		e_rd_q <= emem[eidx_q[EA_W-1:0]];
		if (state_q == S_WA) cmem[n_q[VW-1:0]] <= v_q;
		c_rd_q <= cmem[j_q[VW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ecnt_q <= '0;
			present_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= emit;
			unique case (state_q)
				S_IDLE: begin
					if (!qstat.empty) begin
						case (cmd.op)
							spd_pkg::KIND_LOAD: begin
								if (ecnt_q == EC_W'(MAX_EDGES)) begin
									result <= '{vertex_id: '0, via_label: '0,
										has_predecessor: 1'b0, path_distance: '0,
										last_of_path: 1'b1, status: spd_pkg::ST_FULL};
								end else begin
									ecnt_q <= ecnt_q + 1'b1;
									present_q <= present_q | (V'(1) << cmd.efrom) |
										(V'(1) << cmd.eto);
								end
							end
							spd_pkg::KIND_CLEAR: begin
								ecnt_q <= '0;
								present_q <= '0;
							end
							default: begin
								if (!present_q[cmd.src] || !present_q[cmd.dst]) begin
									result <= '{vertex_id: present_q[cmd.src] ? cmd.dst : cmd.src,
										via_label: '0, has_predecessor: 1'b0,
										path_distance: '0, last_of_path: 1'b1,
										status: present_q[cmd.src] ? spd_pkg::ST_BAD_DST :
											spd_pkg::ST_BAD_SRC};
								end else begin
									src_q <= cmd.src;
									dst_q <= cmd.dst;
									state_q <= S_INIT;
								end
							end
						endcase
					end
				end
				S_INIT: begin
					done_q <= '0;
					reach_q <= V'(1) << src_q;
					idx_q <= '0;
					v_s1 <= 1'b0;
					bestd_q <= spd_pkg::UNREACHED;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					v_s1 <= !idx_q[VW];
					i_s1 <= idx_q[VW-1:0];
					if (!idx_q[VW]) idx_q <= idx_q + 1'b1;
					if (v_s1 && !done_q[i_s1] && reach_q[i_s1] && dm_rd_q.dval < bestd_q) begin
						bestd_q <= dm_rd_q.dval;
						cur_q <= i_s1;
						found_q <= 1'b1;
					end
					if (idx_q[VW] && !v_s1) begin
						if (found_q) begin
							done_q[cur_q] <= 1'b1;
							curd_q <= bestd_q;
							eidx_q <= '0;
							state_q <= S_EA;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_EA: begin
					if (eidx_q == ecnt_q) begin
						idx_q <= '0;
						v_s1 <= 1'b0;
						bestd_q <= spd_pkg::UNREACHED;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EB;
					end
				end
				S_EB: begin
					ed_q <= e_rd_q;
					if (e_rd_q.efrom == cur_q && !done_q[e_rd_q.eto]) begin
						state_q <= S_EC;
					end else begin
						eidx_q <= eidx_q + 1'b1;
						state_q <= S_EA;
					end
				end
				S_EC: begin
					if (better) reach_q[ed_q.eto] <= 1'b1;
					eidx_q <= eidx_q + 1'b1;
					state_q <= S_EA;
				end
				S_RES: begin
					if (!reach_q[dst_q]) begin
						result <= '{vertex_id: dst_q, via_label: '0, has_predecessor: 1'b0,
							path_distance: spd_pkg::UNREACHED, last_of_path: 1'b1,
							status: spd_pkg::ST_UNREACH};
						state_q <= S_IDLE;
					end else begin
						v_q <= dst_q;
						n_q <= '0;
						state_q <= S_WA;
					end
				end
				S_WA: begin
					n_q <= n_q + 1'b1;
					state_q <= S_WB;
				end
				S_WB: begin
					if (dm_rd_q.hp && !n_q[VW]) begin
						v_q <= dm_rd_q.predv;
						state_q <= S_WA;
					end else begin
						j_q <= n_q - 1'b1;
						state_q <= S_OA;
					end
				end
				S_OA: state_q <= S_OB;
				S_OB: begin
					ov_q <= c_rd_q;
					state_q <= S_OC;
				end
				S_OC: begin
					result <= '{vertex_id: ov_q,
						via_label: dm_rd_q.hp ? dm_rd_q.label : 8'd0,
						has_predecessor: dm_rd_q.hp, path_distance: dm_rd_q.dval,
						last_of_path: (j_q == '0), status: spd_pkg::ST_OK};
					if (j_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						j_q <= j_q - 1'b1;
						state_q <= S_OA;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/shortest_path_dijkstra.sv =====
// Top level of the shortest-path engine: front end, command queue and back end.
// Loads and clears are taken one per cycle back to back while no query runs; a status result
// strobes in the cycle after. A query scans all vertices and then all stored edges for each
// vertex it settles, then walks predecessors back from the target and emits the path from
// source to target; while a query runs two more transfers queue before busy rises.
// Asynchronous active-low reset empties the edge store and vertex marks; results cannot stall.
module shortest_path_dijkstra #(
	parameter int MAX_EDGES = spd_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spd_pkg::in_t  item,
	output logic          strobe,
	output spd_pkg::out_t result
);
	spd_pkg::q_stat_t qstat;
	spd_pkg::cmd_t    fcmd, qcmd;
	logic             push, pop;

	spd_front #(.WEIGHT_BITS(WEIGHT_BITS)) u_front (
		.start(start), .busy(busy), .item(item), .qstat(qstat), .push(push), .cmd(fcmd)
	);

	spd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(fcmd), .pop(pop),
		.rdata(qcmd), .qstat(qstat)
	);

	spd_back #(.MAX_EDGES(MAX_EDGES)) u_back (
		.clk(clk), .arst_n(arst_n), .qstat(qstat), .cmd(qcmd), .pop(pop),
		.strobe(strobe), .result(result)
	);
endmodule

// ===== rtl/spd_checker.sv =====
// Port-level checks on result transfers, bound to the top level.
`include "shortest_path_dijkstra_defines.svh"
module spd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          strobe,
	input spd_pkg::out_t result
);
	logic st_err, ok_start;

	assign st_err = strobe && (result.status != spd_pkg::ST_OK);
	assign ok_start = strobe && (result.status == spd_pkg::ST_OK) && !result.has_predecessor;

	`SPD_IMPLIES(a_err_last, st_err, result.last_of_path, "status result not last")
	`SPD_IMPLIES(a_err_nopred, st_err, !result.has_predecessor && !(|result.via_label), "bad pred")
	`SPD_IMPLIES(a_start_zero, ok_start, result.path_distance == '0, "start distance not zero")
	`SPD_NEVER(a_err_in_path, st_err && $past(strobe) && !$past(result.last_of_path), "in path")
endmodule

bind shortest_path_dijkstra spd_checker u_chk (.*);
